>>> hw/rtl/ufq_pkg.sv
// ufq_pkg: types, codes and helper functions of the unicast flow qualifier.
// Used by unicast_flow_qualifier_core; depends on nothing.
package ufq_pkg;

	localparam int NUM_FLOWS_DEF = 2;

	localparam int TDATA_W     = 88;
	localparam int TUSER_W     = 4;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// -10000: no grant received yet
	localparam logic [31:0] NO_GRANT        = 32'hFFFF_D8F0;
	localparam logic [31:0] DUE_DELAY       = 32'd5;
	localparam logic [32:0] LEASE_MARGIN    = 33'd10;
	localparam logic [15:0] CHECK_SYNC_LIMIT = 16'd10;
	localparam logic [15:0] LOW_SYNC_LIMIT  = 16'd10;
	localparam logic [7:0]  UNLOCKED_CLASS  = 8'd248;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
	localparam logic [15:0] LEASE_RESET     = 16'd300;

	typedef enum logic [2:0] {
		OP_STEP      = 3'd0,
		OP_SYNC_GNT  = 3'd1,
		OP_DELAY_GNT = 3'd2,
		OP_ANN_GNT   = 3'd3,
		OP_RESTART   = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEASE  = 1'd0,
		REG_ENABLE = 1'd1
	} cfg_reg_t;

	typedef enum logic [5:0] {
		PH_INIT     = 6'b000001,
		PH_GRANTS   = 6'b000010,
		PH_SYNC     = 6'b000100,
		PH_ANNOUNCE = 6'b001000,
		PH_NORMAL   = 6'b010000,
		PH_SUSPEND  = 6'b100000
	} phase_t;

	localparam logic [2:0] CODE_INIT     = 3'd0;
	localparam logic [2:0] CODE_GRANTS   = 3'd1;
	localparam logic [2:0] CODE_SYNC     = 3'd2;
	localparam logic [2:0] CODE_ANNOUNCE = 3'd3;
	localparam logic [2:0] CODE_NORMAL   = 3'd4;
	localparam logic [2:0] CODE_SUSPEND  = 3'd5;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] sync_due;
		logic [31:0] delay_due;
		logic [31:0] ann_due;
		logic [31:0] sync_grant;
		logic [31:0] delay_grant;
		logic [31:0] ann_grant;
		logic [15:0] phase_count;
		logic [15:0] low_sync_count;
	} flow_rec_t;

	function automatic flow_rec_t rec_reset();
		flow_rec_t r;
		r.phase          = PH_INIT;
		r.sync_due       = '0;
		r.delay_due      = '0;
		r.ann_due        = '0;
		r.sync_grant     = NO_GRANT;
		r.delay_grant    = NO_GRANT;
		r.ann_grant      = NO_GRANT;
		r.phase_count    = '0;
		r.low_sync_count = '0;
		return r;
	endfunction

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		unique case (p)
			PH_INIT:     c = CODE_INIT;
			PH_GRANTS:   c = CODE_GRANTS;
			PH_SYNC:     c = CODE_SYNC;
			PH_ANNOUNCE: c = CODE_ANNOUNCE;
			PH_NORMAL:   c = CODE_NORMAL;
			PH_SUSPEND:  c = CODE_SUSPEND;
			default:     c = CODE_INIT;
		endcase
		return c;
	endfunction

	// grant time against lease window, 33-bit signed
	function automatic logic grant_stale(logic [31:0] g, logic [32:0] win);
		return $signed({g[31], g}) < $signed(win);
	endfunction

	function automatic logic grant_fresh(logic [31:0] g, logic [32:0] win);
		return $signed({g[31], g}) > $signed(win);
	endfunction

endpackage

>>> hw/rtl/unicast_flow_qualifier_core.sv
// unicast_flow_qualifier_core: per-flow qualifier for unicast time-sync sessions.
// Per-flow state in one synchronous memory, read-modify-write with forwarding.
// Depends on ufq_pkg.
//
// Usage:
//   s_* channel takes one transaction per item: s_tuser holds operation and
//   flow index, s_tdata the times, sync rate, clock class and presence flag.
//   m_* channel returns exactly one result transaction per input item.
//   cfg_* channel writes lease_duration (index 0), sync_enable (index 1); it is
//   always ready; the user must write it only while the block is idle (unchecked).
// Pipeline: the input transaction is registered into the compute stage, and its
//   result into the output register that drives m_tvalid and m_tdata.
// Throughput: 1 item per cycle unless m_tready stalls. The flow memory is read at
//   acceptance and written as the item leaves the compute stage; a result being
//   written is forwarded to the read register when the next item has that flow.
// Reset: arst_n clears the pipeline and the per-flow valid bits; a flow never
//   written reads as its reset record. No clearing pass is needed.
// Stall: when m_tready is low the output register holds, the compute stage
//   fills, and s_tready drops until the result is taken.
module unicast_flow_qualifier_core #(
	parameter int NUM_FLOWS = ufq_pkg::NUM_FLOWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [30:0] now_time, [62:31] granted_time, [78:63] sync_rate,
	// [86:79] master_class, [87] master_present
	input  logic [ufq_pkg::TDATA_W-1:0]       s_tdata,
	// [2:0] operation, [3] flow_index
	input  logic [ufq_pkg::TUSER_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] send_sync_request, [1] send_delay_request, [2] send_announce_request,
	// [5:3] flow_phase, [6] flow_qualified, [7] zero
	output logic [ufq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ufq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ufq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

	ufq_pkg::flow_rec_t mem [NUM_FLOWS];
	logic [NUM_FLOWS-1:0] valid_q;

	logic [15:0] lease_q;
	logic        enable_q;

	logic              in_fire;
	logic              in_range;
	logic [AW-1:0]     rd_addr;

	logic              v_s1;
	logic              fire_s1;
	ufq_pkg::op_t      op_s1;
	logic              in_range_s1;
	logic [AW-1:0]     addr_s1;
	logic [30:0]       now_s1;
	logic [31:0]       granted_s1;
	logic [15:0]       rate_s1;
	logic [7:0]        class_s1;
	logic              present_s1;
	ufq_pkg::flow_rec_t rd_s1;
	logic              rd_valid_s1;

	ufq_pkg::flow_rec_t cur;
	ufq_pkg::flow_rec_t nxt;
	logic              rs, rd, ra;
	logic              wr_en;
	logic [ufq_pkg::OUT_TDATA_W-1:0] res;

	logic                            out_valid_q;
	logic [ufq_pkg::OUT_TDATA_W-1:0] out_data_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign in_range  = (32'(s_tuser[3]) < NUM_FLOWS);
	assign rd_addr   = in_range ? AW'(s_tuser[3]) : '0;
	assign fire_s1   = v_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !v_s1 || fire_s1;
	assign wr_en     = fire_s1 && in_range_s1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lease_q  <= ufq_pkg::LEASE_RESET;
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ufq_pkg::cfg_reg_t'(cfg_index))
				ufq_pkg::REG_LEASE:  lease_q  <= cfg_data;
				ufq_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flow memory: write port from compute stage, read port at acceptance
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= nxt;
		end
		if (in_fire) begin
			if (wr_en && addr_s1 == rd_addr) begin
				rd_s1 <= nxt;
			end else begin
				rd_s1 <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (in_fire) begin
				rd_valid_s1 <= valid_q[rd_addr] || (wr_en && addr_s1 == rd_addr);
			end
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1       <= ufq_pkg::op_t'(s_tuser[2:0]);
			in_range_s1 <= in_range;
			addr_s1     <= rd_addr;
			now_s1      <= s_tdata[30:0];
			granted_s1  <= s_tdata[62:31];
			rate_s1     <= s_tdata[78:63];
			class_s1    <= s_tdata[86:79];
			present_s1  <= s_tdata[87];
		end
		if (fire_s1) begin
			out_data_q <= res;
		end
	end

	always_comb begin
		logic [31:0] now32;
		logic [31:0] due_next;
		logic [32:0] window;
		logic        run;
		logic        stale;
		logic        fresh;
		now32    = {1'b0, now_s1};
		due_next = now32 + ufq_pkg::DUE_DELAY;
		window   = {2'b00, now_s1} - ufq_pkg::LEASE_MARGIN - {18'd0, lease_q[15:1]};
		run      = present_s1 && enable_q;
		cur      = rd_valid_s1 ? rd_s1 : ufq_pkg::rec_reset();
		nxt      = cur;
		rs       = 1'b0;
		rd       = 1'b0;
		ra       = 1'b0;
		stale    = ufq_pkg::grant_stale(cur.sync_grant, window) ||
		           ufq_pkg::grant_stale(cur.delay_grant, window) ||
		           ufq_pkg::grant_stale(cur.ann_grant, window);
		fresh    = ufq_pkg::grant_fresh(cur.sync_grant, window) &&
		           ufq_pkg::grant_fresh(cur.delay_grant, window) &&
		           ufq_pkg::grant_fresh(cur.ann_grant, window);
		unique case (op_s1)
			ufq_pkg::OP_STEP: begin
				if (run) begin
					if (now32 > cur.sync_due || cur.sync_grant == ufq_pkg::NO_GRANT) begin
						rs           = 1'b1;
						nxt.sync_due = due_next;
					end
					if (now32 > cur.delay_due || cur.delay_grant == ufq_pkg::NO_GRANT) begin
						rd            = 1'b1;
						nxt.delay_due = due_next;
					end
					if (now32 > cur.ann_due || cur.ann_grant == ufq_pkg::NO_GRANT) begin
						ra          = 1'b1;
						nxt.ann_due = due_next;
					end
				end
				if (rate_s1 <= 16'd1) begin
					if (cur.low_sync_count != ufq_pkg::COUNT_MAX) begin
						nxt.low_sync_count = cur.low_sync_count + 16'd1;
					end
				end else begin
					nxt.low_sync_count = '0;
				end
				unique case (cur.phase)
					ufq_pkg::PH_INIT: begin
						nxt.phase       = ufq_pkg::PH_GRANTS;
						nxt.sync_due    = '0;
						nxt.delay_due   = '0;
						nxt.ann_due     = '0;
						nxt.sync_grant  = ufq_pkg::NO_GRANT;
						nxt.delay_grant = ufq_pkg::NO_GRANT;
						nxt.ann_grant   = ufq_pkg::NO_GRANT;
						nxt.phase_count = '0;
					end
					ufq_pkg::PH_GRANTS: begin
						if (fresh) begin
							nxt.phase       = ufq_pkg::PH_SYNC;
							nxt.phase_count = '0;
						end
					end
					ufq_pkg::PH_SYNC: begin
						if (nxt.low_sync_count == '0) begin
							nxt.phase       = ufq_pkg::PH_ANNOUNCE;
							nxt.phase_count = '0;
						end
						if (stale || nxt.phase_count > ufq_pkg::CHECK_SYNC_LIMIT) begin
							nxt.phase       = ufq_pkg::PH_INIT;
							nxt.phase_count = '0;
						end
					end
					ufq_pkg::PH_ANNOUNCE: begin
						if (class_s1 != ufq_pkg::UNLOCKED_CLASS) begin
							nxt.phase       = ufq_pkg::PH_NORMAL;
							nxt.phase_count = '0;
						end
						if (stale || nxt.low_sync_count > ufq_pkg::LOW_SYNC_LIMIT) begin
							nxt.phase       = ufq_pkg::PH_INIT;
							nxt.phase_count = '0;
						end
					end
					ufq_pkg::PH_NORMAL: begin
						if (stale || nxt.low_sync_count > ufq_pkg::LOW_SYNC_LIMIT) begin
							nxt.phase       = ufq_pkg::PH_INIT;
							nxt.phase_count = '0;
						end else if (class_s1 == ufq_pkg::UNLOCKED_CLASS) begin
							nxt.phase       = ufq_pkg::PH_ANNOUNCE;
							nxt.phase_count = '0;
						end
					end
					ufq_pkg::PH_SUSPEND: nxt.phase = ufq_pkg::PH_INIT;
					default: ;
				endcase
				if (!run) begin
					nxt.phase       = ufq_pkg::PH_SUSPEND;
					nxt.phase_count = '0;
				end
				if (nxt.phase_count != ufq_pkg::COUNT_MAX) begin
					nxt.phase_count = nxt.phase_count + 16'd1;
				end
			end
			ufq_pkg::OP_SYNC_GNT: begin
				nxt.sync_due   = granted_s1;
				nxt.sync_grant = now32;
			end
			ufq_pkg::OP_DELAY_GNT: begin
				nxt.delay_due   = granted_s1;
				nxt.delay_grant = now32;
			end
			ufq_pkg::OP_ANN_GNT: begin
				nxt.ann_due   = granted_s1;
				nxt.ann_grant = now32;
			end
			ufq_pkg::OP_RESTART: begin
				nxt.phase       = ufq_pkg::PH_GRANTS;
				nxt.sync_due    = due_next;
				nxt.delay_due   = due_next;
				nxt.ann_due     = due_next;
				nxt.sync_grant  = ufq_pkg::NO_GRANT;
				nxt.delay_grant = ufq_pkg::NO_GRANT;
				nxt.ann_grant   = ufq_pkg::NO_GRANT;
				nxt.phase_count = '0;
			end
			default: ;
		endcase
		if (in_range_s1) begin
			res = {1'b0, nxt.phase == ufq_pkg::PH_NORMAL,
			       ufq_pkg::phase_code(nxt.phase), ra, rd, rs};
		end else begin
			res = '0;
		end
	end

	a_qualified_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6] == (m_tdata[5:3] == ufq_pkg::CODE_NORMAL)))
		else $error("flow_qualified disagrees with flow_phase");

	a_requests_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (rs || rd || ra) |-> enable_q && present_s1 && op_s1 == ufq_pkg::OP_STEP)
		else $error("request raised while disabled, absent or not stepping");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !fire_s1 |=> v_s1 && $stable(addr_s1) && $stable(rd_s1))
		else $error("stalled compute stage lost its item");

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $onehot(nxt.phase))
		else $error("flow phase written with bad encoding");

endmodule
